FILE: hw/rtl/opp_pkg.sv
`timescale 1ns / 1ps

package opp_pkg;

    // Payload and register widths
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int WIN_W   = 6;
    localparam int SPACE_W = 16;

    // Window step counter holds up to two full windows plus one
    localparam int STEP_W = WIN_W + 1;

    // Window sum covers up to two windows of full-scale values
    localparam int SUM_W  = DATA_W + STEP_W;

    // (centre - delta + 1) * count
    localparam int PROD_W = DATA_W + 1 + STEP_W;

    localparam int RING_DEPTH_DEF = 64;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_PICK_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRE_MAX     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POST_MAX    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRE_AVG     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POST_AVG    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DELTA       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SPACING = 3'd6;

    // Pick modes
    localparam logic [MODE_W-1:0] MODE_LOCAL_MAX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPACING   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  pick_mode;
        logic [WIN_W-1:0]   pre_max;
        logic [WIN_W-1:0]   post_max;
        logic [WIN_W-1:0]   pre_avg;
        logic [WIN_W-1:0]   post_avg;
        logic [DATA_W-1:0]  delta;
        logic [SPACE_W-1:0] min_spacing;
    } opp_cfg_t;

    localparam opp_cfg_t CFG_RESET = '{
        pick_mode:   MODE_SPACING,
        pre_max:     6'd3,
        post_max:    6'd3,
        pre_avg:     6'd10,
        post_avg:    6'd0,
        delta:       32'd0,
        min_spacing: 16'd0
    };

endpackage

FILE: hw/rtl/opp_frame_if.sv
`timescale 1ns / 1ps

interface opp_frame_if
    import opp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] strength;
    logic [DATA_W-1:0] frame_number;
    logic [DATA_W-1:0] time_stamp;

    modport source (
        output valid, strength, frame_number, time_stamp,
        input  ready
    );

    modport sink (
        input  valid, strength, frame_number, time_stamp,
        output ready
    );

endinterface

FILE: hw/rtl/opp_onset_if.sv
`timescale 1ns / 1ps

interface opp_onset_if
    import opp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] onset_frame;
    logic [DATA_W-1:0] onset_time;
    logic [DATA_W-1:0] onset_strength;

    modport source (
        output valid, onset_frame, onset_time, onset_strength,
        input  ready
    );

    modport sink (
        input  valid, onset_frame, onset_time, onset_strength,
        output ready
    );

endinterface

FILE: hw/rtl/onset_peak_picker_core.sv
// Flow: a request that completes the window steps through locate, centre, window walk,
//   multiply, compare and, with an onset, emit; emit waits while an earlier result is held.
// Handshake: a searched request holds ready low until the search ends (and, with an onset,
//   until any output stall clears); one that starts no search frees it next cycle.
// Reset: asynchronous, active low; the ring reads as zero through the fill count, with no
//   clearing pass, and requests are taken from the first cycle after reset.
`timescale 1ns / 1ps

module onset_peak_picker_core
    import opp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    opp_frame_if.sink         frames,
    opp_onset_if.source       onsets
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int FW    = $clog2(RING_DEPTH + 1);
    localparam int ENT_W = 3 * DATA_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(RING_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCATE,
        ST_CENTER,
        ST_WALK,
        ST_MUL,
        ST_CMP,
        ST_EMIT
    } state_t;

    opp_cfg_t cfg;

    state_t              state_reg, state_next;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [DATA_W-1:0]   last_onset_reg, last_onset_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       center_reg, center_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                dir_reg, dir_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [STEP_W-1:0]   pend_k_reg, pend_k_next;
    logic                pend_dir_reg, pend_dir_next;
    logic                pend_live_reg, pend_live_next;
    logic [DATA_W-1:0]   cv_reg, cv_next;
    logic [DATA_W-1:0]   cf_reg, cf_next;
    logic [DATA_W-1:0]   ct_reg, ct_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                max_ok_reg, max_ok_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                ge_reg, ge_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_frame_reg, out_frame_next;
    logic [DATA_W-1:0]   out_time_reg, out_time_next;
    logic [DATA_W-1:0]   out_strength_reg, out_strength_next;

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic [AW-1:0]       wp_inc;
    logic [FW-1:0]       fill_inc;
    logic [STEP_W-1:0]   need;
    logic [AW-1:0]       ptr_dec;
    logic [AW-1:0]       ptr_inc;
    logic [AW-1:0]       center_inc;
    logic [WIN_W-1:0]    n_pre;
    logic [WIN_W-1:0]    n_post;
    logic [STEP_W-1:0]   n_avg;
    logic                ptr_live;
    logic [ENT_W-1:0]    rd_data;
    logic [DATA_W-1:0]   rd_val;
    logic [DATA_W:0]     diff;
    logic [DATA_W:0]     m_plus;
    logic                thr_ok;
    logic                space_ok;
    logic                peak;

    opp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Ring of strength, frame and time stamp, one entry per request
    opp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (wp_reg),
        .wr_data ({frames.strength, frames.frame_number, frames.time_stamp}),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // Handshakes
    assign frames.ready = (state_reg == ST_IDLE);
    assign in_acc       = frames.valid && frames.ready;
    assign out_free     = !out_valid_reg || onsets.ready;
    assign out_load     = (state_reg == ST_EMIT) && out_free;

    // Ring pointer arithmetic
    assign wp_inc     = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
    assign fill_inc   = (fill_reg == FULL_CNT) ? fill_reg : fill_reg + 1'b1;
    assign ptr_dec    = (ptr_reg == '0) ? LAST_IDX : ptr_reg - 1'b1;
    assign ptr_inc    = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
    assign center_inc = (center_reg == LAST_IDX) ? '0 : center_reg + 1'b1;
    assign need       = {1'b0, cfg.pre_max} + {1'b0, cfg.post_max} + 1'b1;

    // Walk lengths cover both the max check and the mean window
    assign n_pre  = (cfg.pre_max > cfg.pre_avg) ? cfg.pre_max : cfg.pre_avg;
    assign n_post = (cfg.post_max > cfg.post_avg) ? cfg.post_max : cfg.post_avg;
    assign n_avg  = {1'b0, cfg.pre_avg} + {1'b0, cfg.post_avg};

    // Entries past the fill count have never been written and read as zero
    assign ptr_live = (fill_reg == FULL_CNT) || (FW'(ptr_reg) < fill_reg);
    assign rd_val   = pend_live_reg ? rd_data[3*DATA_W-1:2*DATA_W] : '0;

    // Threshold: centre >= floor(sum / n) + delta, worked as sum < (centre - delta + 1) * n
    assign diff     = {1'b0, cv_reg} - {1'b0, cfg.delta};
    assign m_plus   = {1'b0, diff[DATA_W-1:0]} + 1'b1;
    assign thr_ok   = ge_reg && ((n_avg == '0) || (PROD_W'(sum_reg) < prod_reg));
    assign space_ok = (cf_reg - last_onset_reg) >= DATA_W'(cfg.min_spacing);
    assign peak     = max_ok_reg &&
                      ((cfg.pick_mode == MODE_LOCAL_MAX) ||
                       (thr_ok && ((cfg.pick_mode == MODE_THRESHOLD) || space_ok)));

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        wp_next           = wp_reg;
        fill_next         = fill_reg;
        last_onset_next   = last_onset_reg;
        ptr_next          = ptr_reg;
        center_next       = center_reg;
        step_next         = step_reg;
        dir_next          = dir_reg;
        pend_valid_next   = 1'b0;
        pend_k_next       = pend_k_reg;
        pend_dir_next     = pend_dir_reg;
        pend_live_next    = pend_live_reg;
        cv_next           = cv_reg;
        cf_next           = cf_reg;
        ct_next           = ct_reg;
        sum_next          = sum_reg;
        max_ok_next       = max_ok_reg;
        prod_next         = prod_reg;
        ge_next           = ge_reg;
        out_valid_next    = out_valid_reg;
        out_frame_next    = out_frame_reg;
        out_time_next     = out_time_reg;
        out_strength_next = out_strength_reg;

        // Drop the result once taken
        if (onsets.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Store the request and start the search when the window is filled and the mode is known
                if (in_acc)
                begin
                    wp_next   = wp_inc;
                    fill_next = fill_inc;
                    if ((32'(fill_inc) >= 32'(need)) &&
                        ((cfg.pick_mode == MODE_LOCAL_MAX) ||
                         (cfg.pick_mode == MODE_THRESHOLD) ||
                         (cfg.pick_mode == MODE_SPACING)))
                    begin
                        ptr_next   = wp_reg;
                        step_next  = {1'b0, cfg.post_max};
                        state_next = ST_LOCATE;
                    end
                end
            end

            ST_LOCATE:
            begin
                // Step back post_max entries from the newest to the centre
                if (step_reg == '0)
                begin
                    center_next = ptr_reg;
                    state_next  = ST_CENTER;
                end
                else
                begin
                    ptr_next  = ptr_dec;
                    step_next = step_reg - 1'b1;
                end
            end

            ST_CENTER:
            begin
                // Capture the centre and open the backward walk
                cv_next     = rd_data[3*DATA_W-1:2*DATA_W];
                cf_next     = rd_data[2*DATA_W-1:DATA_W];
                ct_next     = rd_data[DATA_W-1:0];
                sum_next    = '0;
                max_ok_next = 1'b1;
                ptr_next    = ptr_dec;
                step_next   = STEP_W'(1);
                dir_next    = 1'b0;
                state_next  = ST_WALK;
            end

            ST_WALK:
            begin
                // Check and accumulate the entry read in the previous cycle
                if (pend_valid_reg)
                begin
                    if (!pend_dir_reg)
                    begin
                        if ((pend_k_reg <= {1'b0, cfg.pre_max}) && (rd_val >= cv_reg))
                        begin
                            max_ok_next = 1'b0;
                        end
                        if (pend_k_reg <= {1'b0, cfg.pre_avg})
                        begin
                            sum_next = sum_reg + SUM_W'(rd_val);
                        end
                    end
                    else
                    begin
                        if ((pend_k_reg <= {1'b0, cfg.post_max}) && (rd_val > cv_reg))
                        begin
                            max_ok_next = 1'b0;
                        end
                        if (pend_k_reg <= {1'b0, cfg.post_avg})
                        begin
                            sum_next = sum_reg + SUM_W'(rd_val);
                        end
                    end
                end

                // Issue the next read, turn at the end of the pre window
                if (!dir_reg)
                begin
                    if (step_reg <= {1'b0, n_pre})
                    begin
                        pend_valid_next = 1'b1;
                        pend_k_next     = step_reg;
                        pend_dir_next   = 1'b0;
                        pend_live_next  = ptr_live;
                        ptr_next        = ptr_dec;
                        step_next       = step_reg + 1'b1;
                    end
                    else
                    begin
                        dir_next  = 1'b1;
                        step_next = STEP_W'(1);
                        ptr_next  = center_inc;
                    end
                end
                else
                begin
                    if (step_reg <= {1'b0, n_post})
                    begin
                        pend_valid_next = 1'b1;
                        pend_k_next     = step_reg;
                        pend_dir_next   = 1'b1;
                        pend_live_next  = ptr_live;
                        ptr_next        = ptr_inc;
                        step_next       = step_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                ge_next    = !diff[DATA_W];
                prod_next  = m_plus * n_avg;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                state_next = peak ? ST_EMIT : ST_IDLE;
            end

            ST_EMIT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_frame_next    = cf_reg;
                    out_time_next     = ct_reg;
                    out_strength_next = cv_reg;
                    last_onset_next   = cf_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            fill_reg       <= '0;
            last_onset_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
            dir_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            last_onset_reg <= last_onset_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            step_reg       <= step_next;
            dir_reg        <= dir_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        ptr_reg          <= ptr_next;
        center_reg       <= center_next;
        pend_k_reg       <= pend_k_next;
        pend_dir_reg     <= pend_dir_next;
        pend_live_reg    <= pend_live_next;
        cv_reg           <= cv_next;
        cf_reg           <= cf_next;
        ct_reg           <= ct_next;
        sum_reg          <= sum_next;
        max_ok_reg       <= max_ok_next;
        prod_reg         <= prod_next;
        ge_reg           <= ge_next;
        out_frame_reg    <= out_frame_next;
        out_time_reg     <= out_time_next;
        out_strength_reg <= out_strength_next;
    end

    assign onsets.valid          = out_valid_reg;
    assign onsets.onset_frame    = out_frame_reg;
    assign onsets.onset_time     = out_time_reg;
    assign onsets.onset_strength = out_strength_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond ring depth");

    a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_WALK) && (pend_k_reg != '0))
        else $error("pending ring read outside the window walk");

    a_onset_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (last_onset_reg == out_frame_reg))
        else $error("last onset does not follow the emitted result");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule

FILE: hw/rtl/opp_ram.sv
`timescale 1ns / 1ps

module opp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/opp_regs.sv
`timescale 1ns / 1ps

module opp_regs
    import opp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output opp_cfg_t          cfg
);

    opp_cfg_t             cfg_reg;
    opp_cfg_t             cfg_next;
    logic                 wr_req;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_req  = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];

    // Decode the write request; unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_req)
        begin
            unique case (reg_idx)
                REG_PICK_MODE:   cfg_next.pick_mode   = pwdata[MODE_W-1:0];
                REG_PRE_MAX:     cfg_next.pre_max     = pwdata[WIN_W-1:0];
                REG_POST_MAX:    cfg_next.post_max    = pwdata[WIN_W-1:0];
                REG_PRE_AVG:     cfg_next.pre_avg     = pwdata[WIN_W-1:0];
                REG_POST_AVG:    cfg_next.post_avg    = pwdata[WIN_W-1:0];
                REG_DELTA:       cfg_next.delta       = pwdata[DATA_W-1:0];
                REG_MIN_SPACING: cfg_next.min_spacing = pwdata[SPACE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_PICK_MODE:   prdata = APB_DW'(cfg_reg.pick_mode);
            REG_PRE_MAX:     prdata = APB_DW'(cfg_reg.pre_max);
            REG_POST_MAX:    prdata = APB_DW'(cfg_reg.post_max);
            REG_PRE_AVG:     prdata = APB_DW'(cfg_reg.pre_avg);
            REG_POST_AVG:    prdata = APB_DW'(cfg_reg.post_avg);
            REG_DELTA:       prdata = APB_DW'(cfg_reg.delta);
            REG_MIN_SPACING: prdata = APB_DW'(cfg_reg.min_spacing);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: tb/tb_onset_peak_picker_core.sv
`timescale 1ns / 1ps

module tb_onset_peak_picker_core;
    import opp_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;
    // Longest window walk is three full windows plus the pipeline
    localparam int SETTLE_CYCLES = 3 * 63 + 7 + 24;

    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_UNUSED  = 2'd3;

    localparam logic [DATA_W-1:0] OPENING [24] = '{
        32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'd5, 32'd5, 32'h0,
        32'd1, 32'd9, 32'd9, 32'd9, 32'd2, 32'h0, 32'd7, 32'd3,
        32'd7, 32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0
    };

    typedef enum int {STYLE_WIDE, STYLE_NARROW, STYLE_EDGE, STYLE_MIXED} level_style_t;

    typedef struct packed {
        logic [DATA_W-1:0] strength;
        logic [DATA_W-1:0] frame_number;
        logic [DATA_W-1:0] time_stamp;
    } frame_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] frame;
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] strength;
    } onset_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    opp_frame_if frames_bus ();
    opp_onset_if onsets_bus ();

    onset_peak_picker_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .frames  (frames_bus),
        .onsets  (onsets_bus)
    );

    always #6 clk = ~clk;

    // Shadow of the picker state
    opp_cfg_t          cfg_shadow;
    logic [DATA_W-1:0] strength_hist [DEPTH];
    logic [DATA_W-1:0] frame_hist [DEPTH];
    logic [DATA_W-1:0] stamp_hist [DEPTH];
    int                wr_idx;
    int                filled;
    logic [DATA_W-1:0] last_onset_frame;

    frame_req_t frames_todo [$];
    onset_t     onsets_due [$];
    int         frames_queued = 0;
    int         frames_taken = 0;
    int         mismatches = 0;
    int         send_idle_pct;
    int         recv_idle_pct;
    logic [DATA_W-1:0] next_frame;
    logic [DATA_W-1:0] next_stamp;

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Store one frame and decide whether the centre entry is an onset
    task automatic pick_onset(input frame_req_t req);
        int                centre;
        int                need;
        int                n;
        logic [DATA_W-1:0] cv;
        logic [DATA_W-1:0] gap;
        logic [63:0]       total;
        logic [63:0]       mean;
        logic              is_peak;
        onset_t            hit;

        strength_hist[wr_idx] = req.strength;
        frame_hist[wr_idx]    = req.frame_number;
        stamp_hist[wr_idx]    = req.time_stamp;
        wr_idx = (wr_idx + 1) % DEPTH;
        if (filled < DEPTH)
            filled++;

        need = int'(cfg_shadow.pre_max) + int'(cfg_shadow.post_max) + 1;
        if (filled < need)
            return;

        centre = (wr_idx + DEPTH - (int'(cfg_shadow.post_max) + 1) % DEPTH) % DEPTH;
        cv = strength_hist[centre];

        // Strictly above the pre window, not below the post window
        is_peak = 1'b1;
        for (int i = 1; i <= int'(cfg_shadow.pre_max); i++)
            if (strength_hist[(centre + DEPTH - i) % DEPTH] >= cv)
                is_peak = 1'b0;
        for (int i = 1; i <= int'(cfg_shadow.post_max); i++)
            if (strength_hist[(centre + i) % DEPTH] > cv)
                is_peak = 1'b0;

        // Truncating mean over both averaging windows
        total = '0;
        for (int i = 1; i <= int'(cfg_shadow.pre_avg); i++)
            total += 64'(strength_hist[(centre + DEPTH - i) % DEPTH]);
        for (int i = 1; i <= int'(cfg_shadow.post_avg); i++)
            total += 64'(strength_hist[(centre + i) % DEPTH]);
        n = int'(cfg_shadow.pre_avg) + int'(cfg_shadow.post_avg);
        mean = (n != 0) ? total / 64'(n) : 64'd0;
        gap = frame_hist[centre] - last_onset_frame;

        case (cfg_shadow.pick_mode)
            MODE_LOCAL_MAX: ;
            MODE_THRESHOLD:
                is_peak = is_peak && (64'(cv) >= mean + 64'(cfg_shadow.delta));
            MODE_SPACING:
                is_peak = is_peak && (64'(cv) >= mean + 64'(cfg_shadow.delta))
                          && (gap >= 32'(cfg_shadow.min_spacing));
            default:
                is_peak = 1'b0;
        endcase

        if (!is_peak)
            return;
        hit.frame    = frame_hist[centre];
        hit.stamp    = stamp_hist[centre];
        hit.strength = cv;
        onsets_due = {onsets_due, hit};
        last_onset_frame = frame_hist[centre];
    endtask

    function automatic logic [APB_DW-1:0] field_mask(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_PICK_MODE:   return 32'h3;
            REG_PRE_MAX,
            REG_POST_MAX,
            REG_PRE_AVG,
            REG_POST_AVG:    return 32'h3F;
            REG_DELTA:       return 32'hFFFF_FFFF;
            REG_MIN_SPACING: return 32'hFFFF;
            default:         return 32'h0;
        endcase
    endfunction

    function automatic logic [APB_DW-1:0] shadow_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_PICK_MODE:   return 32'(cfg_shadow.pick_mode);
            REG_PRE_MAX:     return 32'(cfg_shadow.pre_max);
            REG_POST_MAX:    return 32'(cfg_shadow.post_max);
            REG_PRE_AVG:     return 32'(cfg_shadow.pre_avg);
            REG_POST_AVG:    return 32'(cfg_shadow.post_avg);
            REG_DELTA:       return cfg_shadow.delta;
            REG_MIN_SPACING: return 32'(cfg_shadow.min_spacing);
            default:         return 32'h0;
        endcase
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [REG_IDX_W-1:0] idx, output logic [APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write with junk above the field, mirror it, then read it back
    task automatic set_register(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] data;
        logic [APB_DW-1:0] seen;
        data = (value & field_mask(idx)) | ($urandom & ~field_mask(idx));
        apb_write(idx, data);
        case (idx)
            REG_PICK_MODE:   cfg_shadow.pick_mode   = data[MODE_W-1:0];
            REG_PRE_MAX:     cfg_shadow.pre_max     = data[WIN_W-1:0];
            REG_POST_MAX:    cfg_shadow.post_max    = data[WIN_W-1:0];
            REG_PRE_AVG:     cfg_shadow.pre_avg     = data[WIN_W-1:0];
            REG_POST_AVG:    cfg_shadow.post_avg    = data[WIN_W-1:0];
            REG_DELTA:       cfg_shadow.delta       = data;
            REG_MIN_SPACING: cfg_shadow.min_spacing = data[SPACE_W-1:0];
            default: ;
        endcase
        apb_read(idx, seen);
        if (seen !== shadow_value(idx))
            log_mismatch($sformatf("register %0d reads %h want %h", idx, seen,
                                   shadow_value(idx)));
    endtask

    task automatic program_picker(input logic [MODE_W-1:0] mode, input int pre_max,
                                  input int post_max, input int pre_avg, input int post_avg,
                                  input logic [DATA_W-1:0] delta, input int spacing);
        set_register(REG_PICK_MODE, 32'(mode));
        set_register(REG_PRE_MAX, 32'(pre_max));
        set_register(REG_POST_MAX, 32'(post_max));
        set_register(REG_PRE_AVG, 32'(pre_avg));
        set_register(REG_POST_AVG, 32'(post_avg));
        set_register(REG_DELTA, delta);
        set_register(REG_MIN_SPACING, 32'(spacing));
        // Writes to the unmapped slot must leave every register alone
        apb_write(REG_UNMAPPED, $urandom);
    endtask

    // Hold until every request is taken and every onset has come out
    task automatic wait_for_quiet();
        while (frames_taken != frames_queued || onsets_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] make_strength(input level_style_t style);
        level_style_t pick;
        int           r;
        pick = style;
        if (style == STYLE_MIXED)
        begin
            r = $urandom_range(0, 9);
            pick = (r < 4) ? STYLE_WIDE : (r < 7) ? STYLE_NARROW :
                   (r < 8) ? STYLE_EDGE : STYLE_MIXED;
        end
        case (pick)
            STYLE_WIDE:   return $urandom;
            STYLE_NARROW: return $urandom_range(0, 7);
            STYLE_EDGE:
            begin
                r = $urandom_range(0, 3);
                return (r == 0) ? 32'h0 : (r == 1) ? 32'h1 :
                       (r == 2) ? 32'hFFFF_FFFE : 32'hFFFF_FFFF;
            end
            default:      return {16'($urandom_range(0, 255)), 16'h0};
        endcase
    endfunction

    task automatic queue_frames(input int count, input level_style_t style);
        frame_req_t req;
        int         r;
        for (int i = 0; i < count; i++)
        begin
            // Frames mostly advance by one, with occasional skips and jumps
            r = $urandom_range(0, 99);
            if (r < 85)
                next_frame += 1;
            else if (r < 95)
                next_frame += $urandom_range(2, 40);
            else
                next_frame = $urandom;
            if ($urandom_range(0, 9) == 0)
                next_stamp = $urandom;
            else
                next_stamp += $urandom_range(0, 40000);
            req.strength     = make_strength(style);
            req.frame_number = next_frame;
            req.time_stamp   = next_stamp;
            frames_todo = {frames_todo, req};
            frames_queued++;
        end
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] mode, input int pre_max,
                             input int post_max, input int pre_avg, input int post_avg,
                             input logic [DATA_W-1:0] delta, input int spacing,
                             input int count, input level_style_t style);
        wait_for_quiet();
        program_picker(mode, pre_max, post_max, pre_avg, post_avg, delta, spacing);
        queue_frames(count, style);
    endtask

    task automatic run_random_phase(input int count);
        int wide;
        wide = ($urandom_range(0, 3) == 0) ? 63 : 6;
        run_phase(MODE_W'($urandom_range(0, 3)), $urandom_range(0, wide),
                  $urandom_range(0, wide), $urandom_range(0, 16), $urandom_range(0, 16),
                  32'($urandom_range(0, 3)) << 14, $urandom_range(0, 12), count,
                  STYLE_MIXED);
    endtask

    // Request driver: present the next pending frame when the slot is free
    always @(posedge clk)
    begin : frame_driver
        frame_req_t seen;
        frame_req_t req;
        if (!rst_n)
        begin
            frames_bus.valid <= 1'b0;
        end
        else
        begin
            if (frames_bus.valid && frames_bus.ready)
            begin
                seen.strength     = frames_bus.strength;
                seen.frame_number = frames_bus.frame_number;
                seen.time_stamp   = frames_bus.time_stamp;
                pick_onset(seen);
                frames_taken++;
            end
            if (!frames_bus.valid || frames_bus.ready)
            begin
                if (frames_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req = frames_todo.pop_front();
                    frames_bus.valid        <= 1'b1;
                    frames_bus.strength     <= req.strength;
                    frames_bus.frame_number <= req.frame_number;
                    frames_bus.time_stamp   <= req.time_stamp;
                end
                else
                begin
                    frames_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Onset monitor: compare each result with the oldest expected onset
    always @(posedge clk)
    begin : onset_monitor
        onset_t want;
        if (!rst_n)
        begin
            onsets_bus.ready <= 1'b0;
        end
        else
        begin
            if (onsets_bus.valid && onsets_bus.ready)
            begin
                if (onsets_due.size() == 0)
                begin
                    log_mismatch($sformatf("onset at frame %h with none expected",
                                           onsets_bus.onset_frame));
                end
                else
                begin
                    want = onsets_due.pop_front();
                    if (onsets_bus.onset_frame !== want.frame)
                        log_mismatch($sformatf("onset_frame %h want %h",
                                               onsets_bus.onset_frame, want.frame));
                    if (onsets_bus.onset_time !== want.stamp)
                        log_mismatch($sformatf("onset_time %h want %h",
                                               onsets_bus.onset_time, want.stamp));
                    if (onsets_bus.onset_strength !== want.strength)
                        log_mismatch($sformatf("onset_strength %h want %h",
                                               onsets_bus.onset_strength, want.strength));
                end
            end
            onsets_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        frame_req_t req;
        int         r;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        frames_bus.valid        = 1'b0;
        frames_bus.strength     = '0;
        frames_bus.frame_number = '0;
        frames_bus.time_stamp   = '0;
        onsets_bus.ready        = 1'b0;

        cfg_shadow = CFG_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            strength_hist[i] = '0;
            frame_hist[i]    = '0;
            stamp_hist[i]    = '0;
        end
        wr_idx = 0;
        filled = 0;
        last_onset_frame = '0;
        next_frame = 32'hFFFF_FFF0;
        next_stamp = $urandom;
        send_idle_pct = 25;
        recv_idle_pct = 48;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Opening pattern under reset settings: ties, extremes, frame wrap
        for (int i = 0; i < 24; i++)
        begin
            r = i % 3;
            req.strength     = OPENING[i];
            req.frame_number = next_frame;
            req.time_stamp   = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            next_frame += 1;
            frames_todo = {frames_todo, req};
            frames_queued++;
        end

        run_phase(MODE_LOCAL_MAX, 3, 3, 0, 0, 32'h0, 0, 140, STYLE_NARROW);
        run_phase(MODE_THRESHOLD, 1, 1, 10, 5, 32'h0000_8000, 0, 140, STYLE_MIXED);
        run_phase(MODE_SPACING, 2, 2, 8, 8, 32'h0, 5, 70, STYLE_MIXED);
        // Drop the sender until the picker has drained, then carry on
        wait_for_quiet();
        queue_frames(70, STYLE_MIXED);
        run_phase(MODE_LOCAL_MAX, 0, 0, 0, 0, 32'h0, 0, 140, STYLE_WIDE);

        wait_for_quiet();
        send_idle_pct = 48;
        recv_idle_pct = 25;
        // Averaging windows that together exceed the ring overlap one another
        run_phase(MODE_THRESHOLD, 63, 0, 63, 63, 32'h0, 0, 140, STYLE_MIXED);
        run_phase(MODE_SPACING, 0, 63, 20, 0, 32'h0, 65535, 140, STYLE_MIXED);
        run_phase(MODE_UNUSED, 3, 3, 2, 2, 32'h0, 0, 100, STYLE_NARROW);
        // Windows too long for the ring: never enough history
        run_phase(MODE_LOCAL_MAX, 63, 63, 0, 0, 32'h0, 0, 100, STYLE_WIDE);

        wait_for_quiet();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Full-scale margin passes only a full-scale value over a zero mean
        run_phase(MODE_THRESHOLD, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 140, STYLE_EDGE);
        run_phase(MODE_THRESHOLD, 5, 5, 40, 40, 32'h0001_0000, 0, 140, STYLE_MIXED);
        run_random_phase(150);
        run_random_phase(150);

        wait_for_quiet();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
